FILE: src/lgsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgsc_pkg: shared types and helpers of the landing gear stall controller
// Beat payloads, gear and drive codes, register indexes, timer arithmetic.
// ----------------------------------------------------------------------------
package lgsc_pkg;

	localparam int TIMER_WIDTH = 17;
	localparam int TICK_W      = 10;
	localparam int CUR_W       = 16;
	localparam int THR_W       = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;
	// common width for timer vs. threshold compares, one bit of headroom
	localparam int CMP_W = ((TIMER_WIDTH > THR_W) ? TIMER_WIDTH : THR_W) + 1;

	typedef enum logic [2:0] {
		ST_RETRACTED  = 3'd0,
		ST_DEPLOYING  = 3'd1,
		ST_DEPLOYED   = 3'd2,
		ST_RETRACTING = 3'd3,
		ST_FAULT      = 3'd4
	} gear_state_t;

	typedef enum logic [1:0] {
		DRV_STOP    = 2'd0,
		DRV_DEPLOY  = 2'd1,
		DRV_RETRACT = 2'd2
	} drive_t;

	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE         = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STALL_CURRENT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INRUSH_MASK    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_STALL_DEBOUNCE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TRAVEL_TIMEOUT = 3'd4;

	typedef struct packed {
		logic             link_ok;
		logic             deploy_request;
		logic             alert_flag;
		logic [CUR_W-1:0] current_ma;
		logic [TICK_W-1:0] tick_ms;
	} lgsc_in_t;

	typedef struct packed {
		drive_t      drive;
		gear_state_t gear_status;
	} lgsc_out_t;

	typedef struct packed {
		logic             enable;
		logic [THR_W-1:0] stall_current_ma;
		logic [THR_W-1:0] inrush_blank_ms;
		logic [THR_W-1:0] stall_hold_ms;
		logic [THR_W-1:0] travel_timeout_ms;
	} lgsc_cfg_t;

	typedef struct packed {
		gear_state_t            gear_state;
		logic [TIMER_WIDTH-1:0] travel_ms;
		logic [TIMER_WIDTH-1:0] stall_ms;
		logic                   last_request;
		logic                   request_seeded;
	} lgsc_state_t;

	// add elapsed time, saturating at the timer's all-ones value
	function automatic logic [TIMER_WIDTH-1:0] sat_add(
		input logic [TIMER_WIDTH-1:0] t,
		input logic [TICK_W-1:0]      d
	);
		logic [TIMER_WIDTH:0] s;
		s = {1'b0, t} + {{(TIMER_WIDTH + 1 - TICK_W){1'b0}}, d};
		return s[TIMER_WIDTH] ? {TIMER_WIDTH{1'b1}} : s[TIMER_WIDTH-1:0];
	endfunction

	function automatic logic [CMP_W-1:0] ext_timer(input logic [TIMER_WIDTH-1:0] t);
		return {{(CMP_W - TIMER_WIDTH){1'b0}}, t};
	endfunction

	function automatic logic [CMP_W-1:0] ext_thr(input logic [THR_W-1:0] v);
		return {{(CMP_W - THR_W){1'b0}}, v};
	endfunction

endpackage

FILE: src/lgsc_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgsc_cfg: configuration register file
// Takes register write beats and holds the controller settings.
// ----------------------------------------------------------------------------
module lgsc_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lgsc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lgsc_pkg::CFG_DATA_W-1:0]   cfg_data,
	output lgsc_pkg::lgsc_cfg_t               cfg
);
	import lgsc_pkg::*;

	lgsc_cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable            <= 1'b0;
			cfg_q.stall_current_ma  <= 16'd65535;
			cfg_q.inrush_blank_ms   <= 16'd0;
			cfg_q.stall_hold_ms     <= 16'd100;
			cfg_q.travel_timeout_ms <= 16'd65535;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_ENABLE:         cfg_q.enable            <= cfg_data[0];
				CFG_STALL_CURRENT:  cfg_q.stall_current_ma  <= cfg_data[THR_W-1:0];
				CFG_INRUSH_MASK:    cfg_q.inrush_blank_ms   <= cfg_data[THR_W-1:0];
				CFG_STALL_DEBOUNCE: cfg_q.stall_hold_ms     <= cfg_data[THR_W-1:0];
				CFG_TRAVEL_TIMEOUT: cfg_q.travel_timeout_ms <= cfg_data[THR_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

FILE: src/lgsc_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgsc_step: single-tick update of the gear controller
// Computes next controller state and the result beat from one tick.
// ----------------------------------------------------------------------------
module lgsc_step (
	input  lgsc_pkg::lgsc_cfg_t   cfg,
	input  lgsc_pkg::lgsc_state_t cur,
	input  lgsc_pkg::lgsc_in_t    tick,
	output lgsc_pkg::lgsc_state_t nxt,
	output lgsc_pkg::lgsc_out_t   result
);
	import lgsc_pkg::*;

	logic                   edge_dep;
	logic                   edge_ret;
	logic                   over;
	logic                   moving;
	gear_state_t            gear_a;
	logic [TIMER_WIDTH-1:0] travel_a;
	logic [TIMER_WIDTH-1:0] stall_a;
	logic [TIMER_WIDTH-1:0] travel_b;
	logic [TIMER_WIDTH-1:0] stall_b;

	always_comb begin
		nxt      = cur;
		result   = '{drive: DRV_STOP, gear_status: cur.gear_state};
		edge_dep = 1'b0;
		edge_ret = 1'b0;
		gear_a   = cur.gear_state;
		travel_a = cur.travel_ms;
		stall_a  = cur.stall_ms;
		travel_b = '0;
		stall_b  = '0;
		over     = tick.alert_flag || (tick.current_ma >= cfg.stall_current_ma);
		moving   = 1'b0;

		if (cfg.enable) begin
			// command edge detect; first linked tick only seeds
			if (tick.link_ok) begin
				if (cur.request_seeded && (tick.deploy_request != cur.last_request)) begin
					edge_dep = tick.deploy_request;
					edge_ret = !tick.deploy_request;
				end
				nxt.request_seeded = 1'b1;
				nxt.last_request   = tick.deploy_request;
			end

			if (edge_dep && cur.gear_state != ST_DEPLOYING) begin
				gear_a   = ST_DEPLOYING;
				travel_a = '0;
				stall_a  = '0;
			end else if (edge_ret && cur.gear_state != ST_RETRACTING) begin
				gear_a   = ST_RETRACTING;
				travel_a = '0;
				stall_a  = '0;
			end

			nxt.gear_state = gear_a;
			nxt.travel_ms  = travel_a;
			nxt.stall_ms   = stall_a;
			moving = (gear_a == ST_DEPLOYING) || (gear_a == ST_RETRACTING);

			if (moving) begin
				travel_b = sat_add(travel_a, tick.tick_ms);
				if (over && (ext_timer(travel_b) > ext_thr(cfg.inrush_blank_ms)))
					stall_b = sat_add(stall_a, tick.tick_ms);
				else
					stall_b = '0;
				nxt.travel_ms = travel_b;
				nxt.stall_ms  = stall_b;

				// stall ends travel ahead of timeout
				if (ext_timer(stall_b) >= ext_thr(cfg.stall_hold_ms)) begin
					nxt.gear_state = (gear_a == ST_DEPLOYING) ? ST_DEPLOYED : ST_RETRACTED;
					result.drive   = DRV_STOP;
				end else if (ext_timer(travel_b) >= ext_thr(cfg.travel_timeout_ms)) begin
					nxt.gear_state = ST_FAULT;
					result.drive   = DRV_STOP;
				end else begin
					result.drive = (gear_a == ST_DEPLOYING) ? DRV_DEPLOY : DRV_RETRACT;
				end
			end
			result.gear_status = nxt.gear_state;
		end
	end

endmodule

FILE: src/landing_gear_stall_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// landing_gear_stall_controller: gear travel sequencing with stall detection
//
// Usage:
//   tick_valid/tick_ready/tick carry one tick beat (link status, deploy
//   command, overcurrent alert, motor current, elapsed ms). Every tick beat
//   yields exactly one result beat on result_valid/result_ready/result
//   (motor drive and gear status), in order.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write one setting per beat;
//   cfg_ready is always high. Write settings only while no tick is in flight.
//   A tick is taken into the tick register and its result is presented
//   from the result register. Throughput: one tick per cycle while the
//   receiver takes results; the state update sits between the registers.
//   A stalled receiver holds the result register; the tick register keeps
//   taking one more beat, then tick_ready drops until the result drains.
//   Reset (arst_n low): gear retracted, timers zero, command not seeded,
//   controller disabled, thresholds at their defaults.
// ----------------------------------------------------------------------------
module landing_gear_stall_controller (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              tick_valid,
	output logic                              tick_ready,
	input  lgsc_pkg::lgsc_in_t                tick,
	output logic                              result_valid,
	input  logic                              result_ready,
	output lgsc_pkg::lgsc_out_t               result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lgsc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lgsc_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import lgsc_pkg::*;

	lgsc_cfg_t   cfg;
	lgsc_in_t    tick_s1;
	logic        valid_s1;
	lgsc_out_t   result_s2;
	logic        valid_s2;
	lgsc_state_t state_q;
	lgsc_state_t state_nxt;
	lgsc_out_t   result_nxt;
	logic        advance;

	lgsc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	lgsc_step u_step (
		.cfg    (cfg),
		.cur    (state_q),
		.tick   (tick_s1),
		.nxt    (state_nxt),
		.result (result_nxt)
	);

	// advance the held tick when the result register is free or draining
	assign advance      = valid_s1 && (!valid_s2 || result_ready);
	assign tick_ready   = !valid_s1 || advance;
	assign result_valid = valid_s2;
	assign result       = result_s2;

	// tick register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick_ready) begin
			valid_s1 <= tick_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_valid && tick_ready) begin
			tick_s1 <= tick;
		end
	end

	// result register; hold while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_nxt;
		end
	end

	// controller state commits once per tick, as it moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.gear_state     <= ST_RETRACTED;
			state_q.travel_ms      <= '0;
			state_q.stall_ms       <= '0;
			state_q.last_request   <= 1'b0;
			state_q.request_seeded <= 1'b0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

endmodule
